/* rtl/expansion_bus_decoder_banked_ram_assert.svh */
// Assertion macros shared by the decoder RTL.
`ifndef EXPANSION_BUS_DECODER_BANKED_RAM_ASSERT_SVH
`define EXPANSION_BUS_DECODER_BANKED_RAM_ASSERT_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define EBD_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define EBD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/ebd_pkg.sv */
package ebd_pkg;

  localparam int unsigned BANKED_RAM_BYTES = 262144;
  localparam int unsigned DEVICE_RAM_BYTES = 512;
  localparam int unsigned BANK_AW = $clog2(BANKED_RAM_BYTES);
  localparam int unsigned DEV_AW = $clog2(DEVICE_RAM_BYTES);

  // Address map
  localparam logic [15:0] WINDOW_FIRST = 16'h4000;
  localparam logic [15:0] WINDOW_LAST  = 16'h7FFF;
  localparam logic [15:0] D1_FIRST     = 16'hD100;
  localparam logic [15:0] LATCH_EXP    = 16'hD1FF;
  localparam logic [15:0] D5_FIRST     = 16'hD500;
  localparam logic [15:0] LATCH_CART   = 16'hD5FF;
  localparam logic [15:0] D6_FIRST     = 16'hD600;
  localparam logic [15:0] D6_LAST      = 16'hD7FF;
  localparam logic [15:0] D8_FIRST     = 16'hD800;
  localparam logic [15:0] D8_LAST      = 16'hDFFF;
  localparam logic [15:0] PIA_PORT_B   = 16'hD301;
  localparam logic [15:0] PIA_CTL_B    = 16'hD303;
  localparam logic [7:0]  VID_LAST_LO  = 8'h1F;

  localparam logic [7:0] DEVICE_ID_RST = 8'h80;
  localparam logic [7:0] BANK_PORT_RST = 8'hFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_PORT_MODE    = 2'd0;
  localparam logic [1:0] CFG_BANK_PRESENT = 2'd1;
  localparam logic [1:0] CFG_DEVICE_ID    = 2'd2;

  // Bus cycle direction
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef enum logic [1:0] {
    LOG_NONE  = 2'd0,
    LOG_LATCH = 2'd1,
    LOG_VIDEO = 2'd2
  } log_kind_e;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_DEV  = 2'd1,
    SRC_BANK = 2'd2
  } drv_src_e;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_e;

  typedef struct packed {
    logic [15:0] bus_address;
    logic        mode;
    logic [7:0]  bus_byte;
  } ebd_in_t;

  typedef struct packed {
    logic        video_select;
    logic        internal_disable;
    logic        math_rom_disable;
    logic        drive_enable;
    logic [7:0]  drive_byte;
    logic        rom_fetch;
    logic [10:0] rom_offset;
    logic [1:0]  log_kind;
    logic [7:0]  log_offset;
    logic [7:0]  log_byte;
    logic [3:0]  log_flags;
  } ebd_out_t;

endpackage

/* rtl/expansion_bus_decoder_banked_ram.sv */
// Expansion bus decoder with 256 KB banked RAM and 512-byte device RAM.
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat per 6502 bus
// cycle: address, mode (0 write, 1 read) and data byte.
// Output channel (out_valid_o / out_stall_i / out_data_o): one beat per input
// beat, in order: chip-select strobes, read data drive, ROM fetch request and
// the log event of that bus cycle.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 port_mode, 1
// bank_ram_present, 2 device_id; always ready. Write only while idle.
// An accepted beat is registered in the pending stage together with its
// synchronous RAM read data, then moved into the output register.
// Throughput: one beat per cycle while in_stall_o is low; the RAM port is used
// at most once per beat, a read or a write, and a write commits at the accepting
// edge so a following read of the same byte needs no forwarding.
// Reset: latch deselected, PIA control B 0x00, bank port 0xFF. Both RAMs are
// then zeroed by a sweep over every banked address (one banked byte per cycle,
// device RAM in the same pass); in_stall_o stays high during the sweep, config
// writes are still taken.
// Stall: while out_stall_i holds a result, one more beat is taken into the
// pending stage; outside the sweep in_stall_o rises only when both stages are full.
module expansion_bus_decoder_banked_ram (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ebd_pkg::ebd_in_t      in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ebd_pkg::ebd_out_t     out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i
);

  // config registers
  logic       port_mode_q;
  logic       bank_present_q;
  logic [7:0] device_id_q;

  // decoder state
  logic       selected_q, selected_d;
  logic [7:0] pia_ctl_q, pia_ctl_d;
  logic [7:0] bank_port_q, bank_port_d;

  // clear sweep
  ebd_pkg::state_e             state_q, state_d;
  logic [ebd_pkg::BANK_AW-1:0] clr_cnt_q, clr_cnt_d;

  // memories
  logic [7:0] bank_ram [ebd_pkg::BANKED_RAM_BYTES];
  logic [7:0] dev_ram  [ebd_pkg::DEVICE_RAM_BYTES];
  logic [7:0] bank_rd_q, dev_rd_q;

  logic                        bank_we, bank_re, dev_we, dev_re;
  logic [ebd_pkg::BANK_AW-1:0] bank_addr;
  logic [ebd_pkg::DEV_AW-1:0]  dev_addr;
  logic [7:0]                  mem_wd;

  // pending stage (waits for RAM read data) and output register
  logic                 p_valid_q, p_valid_d;
  ebd_pkg::ebd_out_t    p_res_q, res;
  ebd_pkg::drv_src_e    p_src_q, src;
  logic                 out_valid_q, out_valid_d;
  ebd_pkg::ebd_out_t    out_q, out_d;

  logic in_accept, move;

  // decode of the incoming beat
  logic [15:0] addr;
  logic [7:0]  lo, data;
  logic        is_read, exp_mode;
  logic        in_d1, in_d5, in_d6, in_d8, vid_range, latch_exp, latch_cart;
  logic        window, banked_on, bank_hit, latch_hit, now_sel;
  logic        vsel, idis, mdis;
  logic [ebd_pkg::BANK_AW-1:0] bank_index;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_mode_q    <= 1'b1;
      bank_present_q <= 1'b0;
      device_id_q    <= ebd_pkg::DEVICE_ID_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ebd_pkg::CFG_PORT_MODE:    port_mode_q    <= cfg_data_i[0];
        ebd_pkg::CFG_BANK_PRESENT: bank_present_q <= cfg_data_i[0];
        ebd_pkg::CFG_DEVICE_ID:    device_id_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ebd_pkg::ST_RUN) || (p_valid_q && out_valid_q && out_stall_i);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign move        = p_valid_q && (!out_valid_q || !out_stall_i);

  assign addr     = in_data_i.bus_address;
  assign lo       = addr[7:0];
  assign data     = in_data_i.bus_byte;
  assign is_read  = (in_data_i.mode == ebd_pkg::MODE_READ);
  assign exp_mode = port_mode_q;

  assign in_d1      = (addr[15:8] == ebd_pkg::D1_FIRST[15:8]);
  assign in_d5      = (addr[15:8] == ebd_pkg::D5_FIRST[15:8]);
  assign in_d6      = (addr >= ebd_pkg::D6_FIRST) && (addr <= ebd_pkg::D6_LAST);
  assign in_d8      = (addr >= ebd_pkg::D8_FIRST) && (addr <= ebd_pkg::D8_LAST);
  assign vid_range  = in_d1 && (lo <= ebd_pkg::VID_LAST_LO);
  assign latch_exp  = (addr == ebd_pkg::LATCH_EXP);
  assign latch_cart = (addr == ebd_pkg::LATCH_CART);
  assign window     = (addr >= ebd_pkg::WINDOW_FIRST) && (addr <= ebd_pkg::WINDOW_LAST);
  // bank bits are port bits 6,5,3,2; port bit 4 low enables the window
  assign banked_on  = bank_present_q && !bank_port_q[4];
  assign bank_hit   = banked_on && window;
  assign latch_hit  = exp_mode ? latch_exp : latch_cart;
  assign now_sel    = (data == device_id_q);
  assign bank_index = {bank_port_q[6:5], bank_port_q[3:2], addr[13:0]};

  // strobes, log event and state updates of one bus cycle
  always_comb begin
    vsel = 1'b0;
    idis = 1'b0;
    mdis = 1'b0;
    if (exp_mode) begin
      if (selected_q) begin
        idis = (in_d1 && !latch_exp) || in_d6;
        mdis = in_d8;
        vsel = vid_range;
      end
    end else begin
      vsel = selected_q && in_d5 && !latch_cart;
    end
    if (bank_hit) begin
      idis = 1'b1;
    end

    res                  = '0;
    res.video_select     = vsel;
    res.internal_disable = idis;
    res.math_rom_disable = mdis;
    res.log_kind         = ebd_pkg::LOG_NONE;
    src                  = ebd_pkg::SRC_NONE;
    selected_d           = selected_q;
    pia_ctl_d            = pia_ctl_q;
    bank_port_d          = bank_port_q;

    if (is_read) begin
      if (exp_mode && selected_q) begin
        if (in_d8) begin
          res.rom_fetch  = 1'b1;
          res.rom_offset = addr[10:0];
        end else if (in_d6) begin
          res.drive_enable = 1'b1;
          src              = ebd_pkg::SRC_DEV;
        end else if (vid_range) begin
          res.log_kind   = ebd_pkg::LOG_VIDEO;
          res.log_offset = lo;
          res.log_byte   = data;
          res.log_flags  = {idis, mdis, 2'b00};
        end
      end
      if (bank_hit) begin
        res.drive_enable = 1'b1;
        src              = ebd_pkg::SRC_BANK;
      end
    end else begin
      if (latch_hit) begin
        // only a change of selection is taken and logged
        if (now_sel != selected_q) begin
          selected_d     = now_sel;
          res.log_kind   = ebd_pkg::LOG_LATCH;
          res.log_offset = lo;
          res.log_byte   = data;
          res.log_flags  = {idis, mdis, now_sel, 1'b1};
        end
      end else if (exp_mode && vid_range) begin
        res.log_kind   = ebd_pkg::LOG_VIDEO;
        res.log_offset = lo;
        res.log_byte   = data;
        res.log_flags  = {idis, mdis, 2'b01};
      end
      if (addr == ebd_pkg::PIA_CTL_B) begin
        pia_ctl_d = data;
      end
      if ((addr == ebd_pkg::PIA_PORT_B) && pia_ctl_q[2]) begin
        bank_port_d = data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      selected_q  <= 1'b0;
      pia_ctl_q   <= '0;
      bank_port_q <= ebd_pkg::BANK_PORT_RST;
    end else if (in_accept) begin
      selected_q  <= selected_d;
      pia_ctl_q   <= pia_ctl_d;
      bank_port_q <= bank_port_d;
    end
  end

  // clear sweep sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ebd_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ebd_pkg::ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          state_d = ebd_pkg::ST_RUN;
        end
      end
      ebd_pkg::ST_RUN: ;
      default: state_d = ebd_pkg::ST_CLEAR;
    endcase
  end

  // RAM port control: sweep writes zeros, otherwise at most one access per beat
  always_comb begin
    if (state_q == ebd_pkg::ST_CLEAR) begin
      bank_we   = 1'b1;
      bank_re   = 1'b0;
      bank_addr = clr_cnt_q;
      dev_we    = 1'b1;
      dev_re    = 1'b0;
      dev_addr  = clr_cnt_q[ebd_pkg::DEV_AW-1:0];
      mem_wd    = '0;
    end else begin
      bank_we   = in_accept && !is_read && bank_hit;
      bank_re   = in_accept && is_read && bank_hit;
      bank_addr = bank_index;
      dev_we    = in_accept && !is_read && exp_mode && selected_q && in_d6;
      dev_re    = in_accept && is_read && exp_mode && selected_q && in_d6;
      dev_addr  = addr[ebd_pkg::DEV_AW-1:0];
      mem_wd    = data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bank_we) begin
      bank_ram[bank_addr] <= mem_wd;
    end
    if (bank_re) begin
      bank_rd_q <= bank_ram[bank_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dev_we) begin
      dev_ram[dev_addr] <= mem_wd;
    end
    if (dev_re) begin
      dev_rd_q <= dev_ram[dev_addr];
    end
  end

  // pending stage and output register
  always_comb begin
    p_valid_d = p_valid_q;
    if (in_accept) begin
      p_valid_d = 1'b1;
    end else if (move) begin
      p_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (move) begin
      out_valid_d = 1'b1;
      out_d       = p_res_q;
      case (p_src_q)
        ebd_pkg::SRC_DEV:  out_d.drive_byte = dev_rd_q;
        ebd_pkg::SRC_BANK: out_d.drive_byte = bank_rd_q;
        default:           out_d.drive_byte = '0;
      endcase
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      p_res_q <= res;
      p_src_q <= src;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "expansion_bus_decoder_banked_ram_assert.svh"

  `EBD_ASSERT_NOW(a_no_accept_in_clear, state_q == ebd_pkg::ST_CLEAR, in_stall_o, "beat taken during RAM clear")
  `EBD_ASSERT_NOW(a_drive_fetch_excl, out_valid_o, !(out_data_o.drive_enable && out_data_o.rom_fetch), "drive and ROM fetch together")
  `EBD_ASSERT_NOW(a_idle_byte_zero, out_valid_o && !out_data_o.drive_enable, out_data_o.drive_byte == 8'h00, "drive byte set while not driving")
  `EBD_ASSERT_NEXT(a_pending_moves, move && !in_accept, !p_valid_q, "pending beat not released")

endmodule

/* sim/tb_top.sv */
// Bus-cycle decoder bench: a queue of bus cycles feeds a clocked driver, a
// clocked monitor checks every result beat against an in-order store of
// decoded cycles built by a cycle-accurate copy of the decode, latch, PIA
// snoop and both RAMs.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2_000_000; // covers the 256K clear sweep
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_BEATS = 120;
  localparam int unsigned N_PHASES    = 8;

  typedef struct {
    ebd_pkg::ebd_in_t beat;
    int unsigned      gap;
  } bus_item_t;

  // ---------------------------------------------------------------------------
  // Clock, DUT signals
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid  = 1'b0;
  logic              in_stall;
  ebd_pkg::ebd_in_t  in_beat   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  ebd_pkg::ebd_out_t out_beat;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = ebd_pkg::CFG_PORT_MODE;
  logic [7:0]        cfg_data  = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  expansion_bus_decoder_banked_ram uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Decoder copy: configuration, latch, PIA snoop, RAM contents
  // ---------------------------------------------------------------------------
  logic       mode_exp    = 1'b1;
  logic       bank_fitted = 1'b0;
  logic [7:0] dev_id      = ebd_pkg::DEVICE_ID_RST;

  logic       dev_sel     = 1'b0;
  logic [7:0] pia_ctl_b   = 8'h00;
  logic [7:0] bank_port_q = ebd_pkg::BANK_PORT_RST;
  bit   [7:0] bank_mem [ebd_pkg::BANKED_RAM_BYTES];
  bit   [7:0] dev_mem  [ebd_pkg::DEVICE_RAM_BYTES];

  // what was exercised, for the closing summary
  int unsigned n_reads = 0, n_latch = 0, n_video = 0, n_banked = 0;
  int unsigned n_fetch = 0, n_cfg = 0;

  bus_item_t         pending_cycles[$];   // bus cycles waiting to be driven
  ebd_pkg::ebd_out_t decoded_cycles[$];   // expected result beats, oldest first

  int unsigned beats_in  = 0;
  int unsigned beats_out = 0;
  int unsigned n_bad     = 0;
  int unsigned gap_cnt   = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_cnt = 0;
  logic tx_calm  = 1'b0;          // no sender gaps in this phase
  logic rx_calm  = 1'b0;          // no receiver stalls in this phase
  logic hold_off = 1'b0;          // long receiver hold-off

  // One bus cycle: strobes from the state before the cycle, then state update.
  function automatic ebd_pkg::ebd_out_t decode_bus_cycle(input ebd_pkg::ebd_in_t b);
    ebd_pkg::ebd_out_t r;
    logic [15:0] a;
    logic [7:0]  lo;
    logic        in_d1, in_d5, in_d6, in_d8, vid, win, bank_on, now, hit_latch;
    logic [3:0]  strobes;
    logic [17:0] bidx;
    r       = '0;
    a       = b.bus_address;
    lo      = a[7:0];
    in_d1   = a[15:8] == ebd_pkg::D1_FIRST[15:8];
    in_d5   = a[15:8] == ebd_pkg::D5_FIRST[15:8];
    in_d6   = a >= ebd_pkg::D6_FIRST && a <= ebd_pkg::D6_LAST;
    in_d8   = a >= ebd_pkg::D8_FIRST && a <= ebd_pkg::D8_LAST;
    vid     = in_d1 && lo <= ebd_pkg::VID_LAST_LO;
    win     = a >= ebd_pkg::WINDOW_FIRST && a <= ebd_pkg::WINDOW_LAST;
    bank_on = bank_fitted && !bank_port_q[4];
    bidx    = {bank_port_q[6:5], bank_port_q[3:2], a[13:0]};
    hit_latch = mode_exp ? (a == ebd_pkg::LATCH_EXP) : (a == ebd_pkg::LATCH_CART);

    if (mode_exp) begin
      if (dev_sel) begin
        r.internal_disable = (in_d1 && a != ebd_pkg::LATCH_EXP) || in_d6;
        r.math_rom_disable = in_d8;
        r.video_select     = vid;
      end
    end else begin
      r.video_select = dev_sel && in_d5 && a != ebd_pkg::LATCH_CART;
    end
    if (bank_on && win) r.internal_disable = 1'b1;
    strobes = {r.internal_disable, r.math_rom_disable, 2'b00};

    if (b.mode == ebd_pkg::MODE_READ) begin
      n_reads++;
      if (mode_exp && dev_sel) begin
        if (in_d8) begin
          r.rom_fetch  = 1'b1;
          r.rom_offset = a[10:0];
          n_fetch++;
        end else if (in_d6) begin
          r.drive_enable = 1'b1;
          r.drive_byte   = dev_mem[a[8:0]];
        end else if (vid) begin
          r.log_kind   = ebd_pkg::LOG_VIDEO;
          r.log_offset = lo;
          r.log_byte   = b.bus_byte;
          r.log_flags  = strobes;
        end
      end
      if (bank_on && win) begin
        r.drive_enable = 1'b1;
        r.drive_byte   = bank_mem[bidx];
      end
    end else begin
      if (hit_latch) begin
        now = b.bus_byte == dev_id;
        if (now != dev_sel) begin
          dev_sel      = now;
          r.log_kind   = ebd_pkg::LOG_LATCH;
          r.log_offset = lo;
          r.log_byte   = b.bus_byte;
          r.log_flags  = strobes | {2'b00, now, 1'b1};
        end
      end else if (mode_exp && vid) begin
        r.log_kind   = ebd_pkg::LOG_VIDEO;
        r.log_offset = lo;
        r.log_byte   = b.bus_byte;
        r.log_flags  = strobes | 4'b0001;
      end
      if (mode_exp && dev_sel && in_d6) dev_mem[a[8:0]] = b.bus_byte;
      if (a == ebd_pkg::PIA_CTL_B) pia_ctl_b = b.bus_byte;
      if (a == ebd_pkg::PIA_PORT_B && pia_ctl_b[2]) bank_port_q = b.bus_byte;
      if (bank_on && win) bank_mem[bidx] = b.bus_byte;
    end

    if (bank_on && win) n_banked++;
    if (r.log_kind == ebd_pkg::LOG_LATCH) n_latch++;
    if (r.log_kind == ebd_pkg::LOG_VIDEO) n_video++;
    return r;
  endfunction

  function automatic string show(input ebd_pkg::ebd_out_t r);
    return $sformatf("vs=%b id=%b md=%b de=%b db=%h rf=%b ro=%h lk=%0d lo=%h lb=%h lf=%h",
                     r.video_select, r.internal_disable, r.math_rom_disable,
                     r.drive_enable, r.drive_byte, r.rom_fetch, r.rom_offset,
                     r.log_kind, r.log_offset, r.log_byte, r.log_flags);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued cycles, each after its own idle gap
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_beat  <= '0;
      gap_cnt   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decoded_cycles.push_back(decode_bus_cycle(in_beat));
        beats_in++;
      end
      // input slot is free after this edge unless the current beat is stalled
      if (!in_valid || !in_stall) begin
        if (pending_cycles.size() > 0 && gap_cnt >= pending_cycles[0].gap) begin
          in_beat  <= pending_cycles[0].beat;
          in_valid <= 1'b1;
          void'(pending_cycles.pop_front());
          gap_cnt = 0;
        end else begin
          in_valid <= 1'b0;
          if (pending_cycles.size() > 0) gap_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result beat, then draws a stall for the next one
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out++;
        if (decoded_cycles.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result beat: %s", show(out_beat));
        end else begin
          if (out_beat !== decoded_cycles[0]) begin
            n_bad++;
            if (n_bad <= 10)
              $display("beat %0d mismatch\n  exp %s\n  got %s", beats_out,
                       show(decoded_cycles[0]), show(out_beat));
          end
          void'(decoded_cycles.pop_front());
        end
        stall_left = rx_calm ? 0 : $urandom_range(0, 15);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= hold_off || (stall_left > 0);
    end
  end

  // Long receiver hold-off, mid run: the sender keeps offering, so both
  // internal stages fill and in_stall has to rise.
  initial begin
    wait (beats_in >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats in, %0d out", cycle_cnt, beats_in,
               beats_out);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_cycle(input logic [15:0] a, input logic m, input logic [7:0] d);
    bus_item_t it;
    it.beat.bus_address = a;
    it.beat.mode        = m;
    it.beat.bus_byte    = d;
    it.gap              = tx_calm ? 0 : $urandom_range(0, 15);
    pending_cycles.push_back(it);
  endtask

  // Register write; only called with nothing in flight.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ebd_pkg::CFG_PORT_MODE:    mode_exp    = val[0];
      ebd_pkg::CFG_BANK_PRESENT: bank_fitted = val[0];
      ebd_pkg::CFG_DEVICE_ID:    dev_id      = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic pm, input logic bp, input logic [7:0] id);
    write_reg(ebd_pkg::CFG_PORT_MODE, {7'd0, pm});
    write_reg(ebd_pkg::CFG_BANK_PRESENT, {7'd0, bp});
    write_reg(ebd_pkg::CFG_DEVICE_ID, id);
    n_cfg++;
  endtask

  // Wait for every queued cycle to be driven and every result to come back.
  task automatic drain();
    while (pending_cycles.size() != 0 || decoded_cycles.size() != 0 || in_valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random bus cycle, biased toward the decoded regions and the snoop targets.
  function automatic ebd_pkg::ebd_in_t pick_bus_cycle();
    ebd_pkg::ebd_in_t b;
    int unsigned      roll;
    b.bus_address = 16'($urandom_range(0, 65535));
    b.mode        = 1'($urandom_range(0, 1));
    b.bus_byte    = 8'($urandom_range(0, 255));
    roll          = $urandom_range(0, 99);
    if (roll < 25) begin
      b.bus_address = {2'b01, b.bus_address[13:0]};            // banked window
    end else if (roll < 31) begin
      b.bus_address = ebd_pkg::PIA_CTL_B;
      b.mode        = ebd_pkg::MODE_WRITE;
      if ($urandom_range(0, 3) != 0) b.bus_byte[2] = 1'b1;     // mostly exposes port B
    end else if (roll < 37) begin
      b.bus_address = ebd_pkg::PIA_PORT_B;
      b.mode        = ebd_pkg::MODE_WRITE;
      if ($urandom_range(0, 4) != 0) b.bus_byte[4] = 1'b0;     // mostly banking on
    end else if (roll < 47) begin
      b.bus_address = mode_exp ? ebd_pkg::LATCH_EXP : ebd_pkg::LATCH_CART;
      b.mode        = ebd_pkg::MODE_WRITE;
      if ($urandom_range(0, 1) != 0) b.bus_byte = dev_id;
    end else if (roll < 59) begin
      b.bus_address = {ebd_pkg::D1_FIRST[15:8], 3'b000, b.bus_address[4:0]};  // video regs
    end else if (roll < 64) begin
      b.bus_address = {ebd_pkg::D1_FIRST[15:8], b.bus_address[7:0]};
    end else if (roll < 76) begin
      b.bus_address = {7'b1101011, b.bus_address[8:0]};       // D600-D7FF
    end else if (roll < 84) begin
      b.bus_address = {5'b11011, b.bus_address[10:0]};        // D800-DFFF
    end else if (roll < 90) begin
      b.bus_address = {ebd_pkg::D5_FIRST[15:8], b.bus_address[7:0]};
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  logic        ph_mode [N_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  logic        ph_bank [N_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
  logic [7:0]  ph_id   [N_PHASES] = '{8'h80, 8'h00, 8'hFF, 8'h3C, 8'h5A, 8'hFF, 8'h00, 8'hA7};

  initial begin
    ebd_pkg::ebd_in_t b;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, expansion-port mode with banked RAM fitted.
    set_config(1'b1, 1'b1, 8'h80);
    @(negedge clk);
    add_cycle(16'hD100, ebd_pkg::MODE_WRITE, 8'h5A);   // video write logged while deselected
    add_cycle(ebd_pkg::LATCH_EXP, ebd_pkg::MODE_WRITE, 8'h80);  // select
    add_cycle(ebd_pkg::LATCH_EXP, ebd_pkg::MODE_WRITE, 8'h80);  // same value: no event
    add_cycle(16'hD100, ebd_pkg::MODE_READ, 8'hA5);    // video read log
    add_cycle(16'hD11F, ebd_pkg::MODE_WRITE, 8'hFF);
    add_cycle(16'hD120, ebd_pkg::MODE_READ, 8'h00);    // past video regs, still disables
    add_cycle(16'hD1FE, ebd_pkg::MODE_WRITE, 8'h00);
    add_cycle(16'hD7FF, ebd_pkg::MODE_WRITE, 8'h3C);   // device RAM
    add_cycle(16'hD7FF, ebd_pkg::MODE_READ, 8'h00);
    add_cycle(16'hDFFF, ebd_pkg::MODE_READ, 8'h00);    // ROM fetch, top offset
    add_cycle(ebd_pkg::PIA_PORT_B, ebd_pkg::MODE_WRITE, 8'h00); // ignored: DDR exposed
    add_cycle(ebd_pkg::PIA_CTL_B, ebd_pkg::MODE_WRITE, 8'h04);
    add_cycle(ebd_pkg::PIA_PORT_B, ebd_pkg::MODE_WRITE, 8'h6C); // bank 15, banking on
    add_cycle(16'h7FFF, ebd_pkg::MODE_WRITE, 8'h99);
    add_cycle(16'h7FFF, ebd_pkg::MODE_READ, 8'h00);
    add_cycle(ebd_pkg::PIA_PORT_B, ebd_pkg::MODE_WRITE, 8'h00); // bank 0
    add_cycle(16'h4000, ebd_pkg::MODE_READ, 8'h00);
    add_cycle(ebd_pkg::LATCH_EXP, ebd_pkg::MODE_WRITE, 8'h7F);  // deselect
    add_cycle(16'h0000, ebd_pkg::MODE_READ, 8'h00);
    add_cycle(16'hFFFF, ebd_pkg::MODE_WRITE, 8'hFF);
    drain();

    // Directed, cartridge mode.
    set_config(1'b0, 1'b1, 8'h80);
    @(negedge clk);
    add_cycle(ebd_pkg::LATCH_CART, ebd_pkg::MODE_WRITE, 8'h80); // select via D5FF
    add_cycle(16'hD500, ebd_pkg::MODE_READ, 8'hC0);
    add_cycle(ebd_pkg::LATCH_CART, ebd_pkg::MODE_READ, 8'h00);  // latch address: no strobe
    add_cycle(ebd_pkg::LATCH_EXP, ebd_pkg::MODE_WRITE, 8'h00);  // not a latch in this mode
    add_cycle(ebd_pkg::PIA_PORT_B, ebd_pkg::MODE_WRITE, 8'h10); // banking off
    add_cycle(16'h4000, ebd_pkg::MODE_READ, 8'h00);
    add_cycle(ebd_pkg::LATCH_CART, ebd_pkg::MODE_WRITE, 8'h01); // deselect
    drain();

    // Random phases across settings; each opens with a well-formed setup
    // (port B exposed, bank port bit 4 low, device selected), then random cycles.
    for (int p = 0; p < N_PHASES; p++) begin
      set_config(ph_mode[p], ph_bank[p], (p == 4) ? 8'($urandom_range(0, 255)) : ph_id[p]);
      @(negedge clk);
      tx_calm = (p % 3 == 1);
      rx_calm = (p % 3 == 2);
      add_cycle(ebd_pkg::PIA_CTL_B, ebd_pkg::MODE_WRITE, 8'($urandom_range(0, 255)) | 8'h04);
      add_cycle(ebd_pkg::PIA_PORT_B, ebd_pkg::MODE_WRITE, 8'($urandom_range(0, 255)) & 8'hEF);
      add_cycle(mode_exp ? ebd_pkg::LATCH_EXP : ebd_pkg::LATCH_CART, ebd_pkg::MODE_WRITE,
                dev_id);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        b = pick_bus_cycle();
        add_cycle(b.bus_address, b.mode, b.bus_byte);
      end
      drain();
    end

    // result beats that never came back would show up here
    repeat (20) @(posedge clk);
    n_bad += decoded_cycles.size();

    $display("covered %0d bus cycles (%0d reads) over %0d settings, %0d select changes,",
             beats_in, n_reads, n_cfg, n_latch);
    $display("%0d video register events, %0d banked RAM accesses, %0d ROM fetches",
             n_video, n_banked, n_fetch);
    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ebd_pkg.sv
rtl/expansion_bus_decoder_banked_ram.sv
sim/tb_top.sv
